[rtl/core/sbz_pkg.sv]
// Shared types, constants and tables for the sliding cubic Bezier sampler.
// Used by the top level, sbz_window and sbz_eval under rtl/core; depends on nothing else.
package sbz_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int MAX_SAMPLES     = 64;
   localparam int CNT_W           = 7;     // sample_count register width
   localparam int J_W             = 6;     // sample index within a window
   localparam int T_W             = 17;    // t and u, unsigned Q0.16 up to one
   localparam int SQ_W            = 34;    // t*t and u*u

   localparam logic [CNT_W-1:0] SAMPLE_COUNT_RST = 7'd16;
   localparam logic [CNT_W-1:0] SAMPLE_COUNT_MIN = 7'd2;
   localparam logic [CNT_W-1:0] SAMPLE_COUNT_MAX = CNT_W'(MAX_SAMPLES);
   localparam logic [T_W-1:0]   T_ONE            = 17'h10000;
   localparam logic [T_W-1:0]   T_INC_RST        = 17'd4369;

   // Step of t for a window of k+1 points: floor(2^16 / k).
   localparam logic [T_W-1:0] INC_TABLE [64] = '{
      17'd65536, 17'd65536, 17'd32768, 17'd21845, 17'd16384, 17'd13107, 17'd10922,
      17'd9362,  17'd8192,  17'd7281,  17'd6553,  17'd5957,  17'd5461,  17'd5041,
      17'd4681,  17'd4369,  17'd4096,  17'd3855,  17'd3640,  17'd3449,  17'd3276,
      17'd3120,  17'd2978,  17'd2849,  17'd2730,  17'd2621,  17'd2520,  17'd2427,
      17'd2340,  17'd2259,  17'd2184,  17'd2114,  17'd2048,  17'd1985,  17'd1927,
      17'd1872,  17'd1820,  17'd1771,  17'd1724,  17'd1680,  17'd1638,  17'd1598,
      17'd1560,  17'd1524,  17'd1489,  17'd1456,  17'd1424,  17'd1394,  17'd1365,
      17'd1337,  17'd1310,  17'd1285,  17'd1260,  17'd1236,  17'd1213,  17'd1191,
      17'd1170,  17'd1149,  17'd1129,  17'd1110,  17'd1092,  17'd1074,  17'd1057,
      17'd1040
   };

   typedef struct packed {
      logic [CNT_W-1:0] count;   // effective points per window, 2 .. MAX_SAMPLES
      logic [T_W-1:0]   inc;     // t step, Q0.16
   } cfg_type;

   // Multiplier schedule for one curve point, one operation a cycle.
   typedef enum logic [3:0] {
      OP_UU, OP_TT, OP_UUU, OP_UUT, OP_UTT, OP_TTT,
      OP_X0, OP_X1, OP_X2, OP_X3,
      OP_Y0, OP_Y1, OP_Y2, OP_Y3,
      OP_DRAIN
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CALC,
      ST_LOAD
   } state_type;

endpackage

[rtl/core/sliding_cubic_bezier_sampler.sv]
// Sliding cubic Bezier sampler, top level: configuration register, channel
// packing, waypoint window and point evaluator. Uses sbz_pkg and rtl/core.
//
// Request channel (req_*): one waypoint per request, x and y in signed
// fixed point, path start in req_tuser. The first three waypoints of a path
// are only stored; each one after that closes a window of four and yields
// sample_count curve points on the result channel (rsp_*), t rising from 0
// to 1, the point at t = 1 flagged by rsp_tlast.
// Each point of a window runs the one shared multiplier through the Bernstein
// weights, then the weighted sums, then a drain step, and is then loaded into
// the output register. req_tready stays low from the request that closes a
// window until the last point of that window enters the output register.
// csr_wen writes sample_count (values below 2 act as 2, above 64 as 64);
// write it only while the block is idle.
// Reset (synchronous) clears the window, sets sample_count to 16 and empties
// the output register. When rsp_tready is low the current point holds in
// the output register and the next one waits, finished, behind it, adding
// the stall cycles to the window.
module sliding_cubic_bezier_sampler #(
   parameter int COORD_WIDTH = sbz_pkg::COORD_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [((2*COORD_WIDTH+7)/8)*8-1:0] req_tdata,   // waypoint_x, waypoint_y
   input  logic                     req_tuser,   // path_start
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [((2*COORD_WIDTH+7)/8)*8-1:0] rsp_tdata,   // sample_x, sample_y
   output logic                     rsp_tlast,   // last_sample
   input  logic                     csr_wen,
   input  logic [sbz_pkg::CNT_W-1:0] csr_wdata   // sample_count
);

   localparam int TD_W = ((2 * COORD_WIDTH + 7) / 8) * 8;
   localparam int CNT_W = sbz_pkg::CNT_W;

   sbz_pkg::cfg_type cfg_ff, cfg_in;
   logic [CNT_W-1:0] eff_count;

   logic signed [COORD_WIDTH-1:0] win_x [4];
   logic signed [COORD_WIDTH-1:0] win_y [4];
   logic signed [COORD_WIDTH-1:0] out_x, out_y;
   logic start, done;

   always_comb begin
      if (csr_wdata < sbz_pkg::SAMPLE_COUNT_MIN) begin
         eff_count = sbz_pkg::SAMPLE_COUNT_MIN;
      end else if (csr_wdata > sbz_pkg::SAMPLE_COUNT_MAX) begin
         eff_count = sbz_pkg::SAMPLE_COUNT_MAX;
      end else begin
         eff_count = csr_wdata;
      end
      cfg_in = cfg_ff;
      if (csr_wen) begin
         cfg_in.count = eff_count;
         cfg_in.inc   = sbz_pkg::INC_TABLE[sbz_pkg::J_W'(eff_count - CNT_W'(1))];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.count <= sbz_pkg::SAMPLE_COUNT_RST;
         cfg_ff.inc   <= sbz_pkg::T_INC_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sbz_window #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_window (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .waypoint_x ($signed(req_tdata[COORD_WIDTH-1:0])),
      .waypoint_y ($signed(req_tdata[2*COORD_WIDTH-1:COORD_WIDTH])),
      .path_start (req_tuser),
      .done       (done),
      .start      (start),
      .win_x      (win_x),
      .win_y      (win_y)
   );

   sbz_eval #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_eval (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .cfg        (cfg_ff),
      .p_x        (win_x),
      .p_y        (win_y),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_x      (out_x),
      .rsp_y      (out_y),
      .rsp_last   (rsp_tlast),
      .done       (done)
   );

   assign rsp_tdata = TD_W'({out_y, out_x});

endmodule

[rtl/core/sbz_mul.sv]
// Shared signed multiplier with a registered product.
// Depends on nothing; operand widths come from the instantiating module.
module sbz_mul #(
   parameter int A_W = 35,
   parameter int B_W = 32
) (
   input  logic                        clock,
   input  logic signed [A_W-1:0]       mul_a,
   input  logic signed [B_W-1:0]       mul_b,
   output logic signed [A_W+B_W-1:0]   prod_ff
);

   logic signed [A_W+B_W-1:0] prod_in;

   assign prod_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

[rtl/core/sbz_window.sv]
// Waypoint window: holds the three previous waypoints and the current one,
// and starts an evaluation once a window of four is complete. Uses sbz_pkg.
module sbz_window #(
   parameter int COORD_WIDTH = sbz_pkg::COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_WIDTH-1:0] waypoint_x,
   input  logic signed [COORD_WIDTH-1:0] waypoint_y,
   input  logic                          path_start,
   input  logic                          done,
   output logic                          start,
   output logic signed [COORD_WIDTH-1:0] win_x [4],
   output logic signed [COORD_WIDTH-1:0] win_y [4]
);

   logic signed [COORD_WIDTH-1:0] held_x_ff [3];
   logic signed [COORD_WIDTH-1:0] held_y_ff [3];
   logic signed [COORD_WIDTH-1:0] cur_x_ff;
   logic signed [COORD_WIDTH-1:0] cur_y_ff;
   logic [1:0] cnt_ff, cnt_in;
   logic       busy_ff, busy_in;
   logic       start_ff, start_in;
   logic [1:0] base;
   logic       accept;
   logic       full;

   assign req_ready = !busy_ff;
   assign accept    = req_valid && !busy_ff;
   // path start drops the held points before this waypoint is taken
   assign base      = path_start ? 2'd0 : cnt_ff;
   assign full      = (base == 2'd3);

   always_comb begin
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      start_in = 1'b0;
      if (accept && !full) begin
         cnt_in = base + 2'd1;
      end else if (accept) begin
         cnt_in   = base;
         busy_in  = 1'b1;
         start_in = 1'b1;
      end
      if (done) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= 2'd0;
         busy_ff  <= 1'b0;
         start_ff <= 1'b0;
      end else begin
         cnt_ff   <= cnt_in;
         busy_ff  <= busy_in;
         start_ff <= start_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !full) begin
         held_x_ff[base] <= waypoint_x;
         held_y_ff[base] <= waypoint_y;
      end else if (accept) begin
         cur_x_ff <= waypoint_x;
         cur_y_ff <= waypoint_y;
      end
      // slide by one once the window has been sampled
      if (done) begin
         held_x_ff[0] <= held_x_ff[1];
         held_x_ff[1] <= held_x_ff[2];
         held_x_ff[2] <= cur_x_ff;
         held_y_ff[0] <= held_y_ff[1];
         held_y_ff[1] <= held_y_ff[2];
         held_y_ff[2] <= cur_y_ff;
      end
   end

   assign start    = start_ff;
   assign win_x[0] = held_x_ff[0];
   assign win_x[1] = held_x_ff[1];
   assign win_x[2] = held_x_ff[2];
   assign win_x[3] = cur_x_ff;
   assign win_y[0] = held_y_ff[0];
   assign win_y[1] = held_y_ff[1];
   assign win_y[2] = held_y_ff[2];
   assign win_y[3] = cur_y_ff;

   a_done_when_busy: assert property (@(posedge clock) disable iff (reset)
      done |-> busy_ff) else $error("window slid while no evaluation was running");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |-> busy_ff) else $error("evaluation started without a held window");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start_ff |=> !start_ff) else $error("two evaluation starts in a row");

endmodule

[rtl/core/sbz_eval.sv]
// Curve point evaluator: a sequencer drives the shared multiplier through the
// Bernstein weights and the weighted sums, then rounds, saturates and holds
// each point in the output register. Uses sbz_pkg and sbz_mul.
module sbz_eval #(
   parameter int COORD_WIDTH = sbz_pkg::COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  sbz_pkg::cfg_type              cfg,
   input  logic signed [COORD_WIDTH-1:0] p_x [4],
   input  logic signed [COORD_WIDTH-1:0] p_y [4],
   input  logic                          rsp_tready,
   output logic                          rsp_tvalid,
   output logic signed [COORD_WIDTH-1:0] rsp_x,
   output logic signed [COORD_WIDTH-1:0] rsp_y,
   output logic                          rsp_last,
   output logic                          done
);

   localparam int CW      = COORD_WIDTH;
   localparam int W_BITS  = 62 - CW;             // weight fraction bits
   localparam int W_W     = W_BITS + 1;          // weight reaches one
   localparam int W_SHIFT = 48 - W_BITS;
   localparam int A_W     = (CW > 35) ? CW : 35;
   localparam int B_W     = (W_W + 1 > 18) ? W_W + 1 : 18;
   localparam int P_W     = A_W + B_W;
   localparam int E_W     = 51;                  // 3 * Q0.48 term
   localparam int ACC_W   = CW + W_W + 2;
   localparam int R_W     = ACC_W - W_BITS;
   localparam int T_W     = sbz_pkg::T_W;
   localparam int SQ_W    = sbz_pkg::SQ_W;
   localparam int J_W     = sbz_pkg::J_W;
   localparam int CNT_W   = sbz_pkg::CNT_W;

   localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};

   sbz_pkg::state_type state_ff, state_in;
   sbz_pkg::op_type    op_ff, op_in;
   sbz_pkg::op_type    tag_ff;
   logic               tag_vld_ff, tag_vld_in;
   logic [T_W-1:0]     t_ff, t_in;
   logic [J_W-1:0]     j_ff, j_in;
   logic [SQ_W-1:0]    uu_ff, tt_ff;
   logic [W_W-1:0]     w_ff [4];
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [CW-1:0]    res_x_ff;
   logic                    out_vld_ff, out_vld_in;
   logic signed [CW-1:0]    out_x_ff, out_y_ff;
   logic                    out_last_ff;

   logic [T_W-1:0]          u_w;
   logic signed [A_W-1:0]   mul_a;
   logic signed [B_W-1:0]   mul_b;
   logic signed [P_W-1:0]   prod_ff;
   logic                    mul3;
   logic [E_W-1:0]          e_raw, e_sum, e_rnd;
   logic [W_W-1:0]          w_new;
   logic signed [ACC_W-1:0] prod_ext;
   logic signed [ACC_W-1:0] acc_rnd;
   logic signed [R_W-1:0]   acc_sh;
   logic                    acc_ovf;
   logic signed [CW-1:0]    sat_w;
   logic                    last_w;
   logic                    near_last;
   logic                    out_free;
   logic                    load_out;
   logic                    issue;

   assign u_w       = sbz_pkg::T_ONE - t_ff;
   assign last_w    = ({1'b0, j_ff} == cfg.count - CNT_W'(1));
   assign near_last = ({1'b0, j_ff} + CNT_W'(2) == cfg.count);
   assign out_free  = !out_vld_ff || rsp_tready;

   // operand select for the issued operation
   always_comb begin
      case (op_ff)
         sbz_pkg::OP_UU: begin
            mul_a = A_W'($signed({1'b0, u_w}));
            mul_b = B_W'($signed({1'b0, u_w}));
         end
         sbz_pkg::OP_TT: begin
            mul_a = A_W'($signed({1'b0, t_ff}));
            mul_b = B_W'($signed({1'b0, t_ff}));
         end
         sbz_pkg::OP_UUU: begin
            mul_a = A_W'($signed({1'b0, uu_ff}));
            mul_b = B_W'($signed({1'b0, u_w}));
         end
         sbz_pkg::OP_UUT: begin
            mul_a = A_W'($signed({1'b0, uu_ff}));
            mul_b = B_W'($signed({1'b0, t_ff}));
         end
         sbz_pkg::OP_UTT: begin
            mul_a = A_W'($signed({1'b0, tt_ff}));
            mul_b = B_W'($signed({1'b0, u_w}));
         end
         sbz_pkg::OP_TTT: begin
            mul_a = A_W'($signed({1'b0, tt_ff}));
            mul_b = B_W'($signed({1'b0, t_ff}));
         end
         sbz_pkg::OP_X0: begin
            mul_a = A_W'(p_x[0]);
            mul_b = B_W'($signed({1'b0, w_ff[0]}));
         end
         sbz_pkg::OP_X1: begin
            mul_a = A_W'(p_x[1]);
            mul_b = B_W'($signed({1'b0, w_ff[1]}));
         end
         sbz_pkg::OP_X2: begin
            mul_a = A_W'(p_x[2]);
            mul_b = B_W'($signed({1'b0, w_ff[2]}));
         end
         sbz_pkg::OP_X3: begin
            mul_a = A_W'(p_x[3]);
            mul_b = B_W'($signed({1'b0, w_ff[3]}));
         end
         sbz_pkg::OP_Y0: begin
            mul_a = A_W'(p_y[0]);
            mul_b = B_W'($signed({1'b0, w_ff[0]}));
         end
         sbz_pkg::OP_Y1: begin
            mul_a = A_W'(p_y[1]);
            mul_b = B_W'($signed({1'b0, w_ff[1]}));
         end
         sbz_pkg::OP_Y2: begin
            mul_a = A_W'(p_y[2]);
            mul_b = B_W'($signed({1'b0, w_ff[2]}));
         end
         sbz_pkg::OP_Y3: begin
            mul_a = A_W'(p_y[3]);
            mul_b = B_W'($signed({1'b0, w_ff[3]}));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   sbz_mul #(
      .A_W (A_W),
      .B_W (B_W)
   ) u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod_ff)
   );

   // Bernstein weight: optional times three, round half up to Q0.W_BITS
   assign mul3  = (tag_ff == sbz_pkg::OP_UUT) || (tag_ff == sbz_pkg::OP_UTT);
   assign e_raw = E_W'(prod_ff[48:0]);
   assign e_sum = e_raw + (mul3 ? (e_raw << 1) : '0);
   assign e_rnd = e_sum + (E_W'(1) << (W_SHIFT - 1));
   assign w_new = e_rnd[W_SHIFT +: W_W];

   assign prod_ext = ACC_W'($signed(prod_ff[CW+W_W-1:0]));

   // round the weighted sum half up, then clamp to the coordinate range
   assign acc_rnd = acc_ff + (ACC_W'(1) <<< (W_BITS - 1));
   assign acc_sh  = acc_rnd[ACC_W-1:W_BITS];
   assign acc_ovf = !((&acc_sh[R_W-1:CW-1]) || !(|acc_sh[R_W-1:CW-1]));
   assign sat_w   = acc_ovf ? (acc_sh[R_W-1] ? C_MIN : C_MAX) : acc_sh[CW-1:0];

   // next state
   always_comb begin
      case (state_ff)
         sbz_pkg::ST_IDLE: state_in = start ? sbz_pkg::ST_CALC : sbz_pkg::ST_IDLE;
         sbz_pkg::ST_CALC: begin
            state_in = (op_ff == sbz_pkg::OP_DRAIN) ? sbz_pkg::ST_LOAD : sbz_pkg::ST_CALC;
         end
         sbz_pkg::ST_LOAD: begin
            if (out_free) begin
               state_in = last_w ? sbz_pkg::ST_IDLE : sbz_pkg::ST_CALC;
            end else begin
               state_in = sbz_pkg::ST_LOAD;
            end
         end
         default: state_in = sbz_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      issue      = 1'b0;
      load_out   = 1'b0;
      op_in      = sbz_pkg::OP_UU;
      t_in       = t_ff;
      j_in       = j_ff;
      case (state_ff)
         sbz_pkg::ST_IDLE: begin
            if (start) begin
               t_in = '0;
               j_in = '0;
            end
         end
         sbz_pkg::ST_CALC: begin
            issue = (op_ff != sbz_pkg::OP_DRAIN);
            op_in = issue ? sbz_pkg::op_type'(op_ff + 4'd1) : sbz_pkg::OP_UU;
         end
         sbz_pkg::ST_LOAD: begin
            load_out = out_free;
            // advance t; the final point sits exactly at one
            if (out_free && !last_w) begin
               j_in = j_ff + J_W'(1);
               t_in = near_last ? sbz_pkg::T_ONE : t_ff + cfg.inc;
            end
         end
         default: begin
            issue = 1'b0;
         end
      endcase
      tag_vld_in = issue;
      done       = load_out && last_w;
      out_vld_in = load_out ? 1'b1 : (rsp_tready ? 1'b0 : out_vld_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= sbz_pkg::ST_IDLE;
         op_ff      <= sbz_pkg::OP_UU;
         tag_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         op_ff      <= op_in;
         tag_vld_ff <= tag_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff <= op_ff;
      t_ff   <= t_in;
      j_ff   <= j_in;
      if (tag_vld_ff) begin
         case (tag_ff)
            sbz_pkg::OP_UU:  uu_ff  <= prod_ff[SQ_W-1:0];
            sbz_pkg::OP_TT:  tt_ff  <= prod_ff[SQ_W-1:0];
            sbz_pkg::OP_UUU: w_ff[0] <= w_new;
            sbz_pkg::OP_UUT: w_ff[1] <= w_new;
            sbz_pkg::OP_UTT: w_ff[2] <= w_new;
            sbz_pkg::OP_TTT: w_ff[3] <= w_new;
            sbz_pkg::OP_X0:  acc_ff <= prod_ext;
            sbz_pkg::OP_Y0: begin
               res_x_ff <= sat_w;   // accumulator still holds the x sum here
               acc_ff   <= prod_ext;
            end
            default: acc_ff <= acc_ff + prod_ext;
         endcase
      end
      if (load_out) begin
         out_x_ff    <= res_x_ff;
         out_y_ff    <= sat_w;
         out_last_ff <= last_w;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_x      = out_x_ff;
   assign rsp_y      = out_y_ff;
   assign rsp_last   = out_last_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> state_ff == sbz_pkg::ST_IDLE) else $error("start while evaluating");
   a_tag_calc: assert property (@(posedge clock) disable iff (reset)
      tag_vld_ff |-> $past(state_ff) == sbz_pkg::ST_CALC)
      else $error("product captured outside calculation");
   a_last_point: assert property (@(posedge clock) disable iff (reset)
      done |=> out_vld_ff && out_last_ff && state_ff == sbz_pkg::ST_IDLE)
      else $error("final point not marked or sequencer not idle");

endmodule
